>>> rtl/i2csm_pkg.sv
// Package for the I2C slave memory event handler.
// Holds the memory geometry, the bus event codes and the phase and control state types.
// No dependencies.
package i2csm_pkg;

    // Memory depth must be a power of two: the address is reduced by masking.
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam int ADDR_W = 16;
    localparam int BYTE_W = 8;

    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_ACK   = 3'd1,
        ACT_NACK  = 3'd2,
        ACT_STOP  = 3'd3,
        ACT_WAKE  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_ADDR = 2'd0,
        PH_RECV = 2'd1,
        PH_SEND = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_DONE  = 2'd2
    } ctrl_state_t;

    function automatic phase_t start_phase(input logic mode);
        return mode ? PH_RECV : PH_ADDR;
    endfunction

endpackage

>>> rtl/i2csm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies on the package.
module i2csm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/i2c_slave_memory_event_handler.sv
// I2C slave memory event handler: each bus event transaction yields one result transaction.
// Flow: the event is registered into the lookup state, and the result is registered from
// there once the output register is free, so a stall on m_tready holds the event in lookup.
// A new event is taken only in the idle state, after the previous result is registered.
// Reset: aresetn is synchronous, active low; afterwards a clearing pass writes zero to
// all 256 memory bytes, one per cycle, and no event is taken until that pass ends.
// Depends on i2csm_pkg and i2csm_ram.
module i2c_slave_memory_event_handler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // wake_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [0] slave_read, [8:1] rx_byte, [15:9] zero
    input  logic [2:0]  s_tuser,       // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // [0] send_valid, [8:1] send_byte, [9] stored,
                                       // [10] woke, [11] woke_by_address, [15:12] zero
);
    import i2csm_pkg::*;

    ctrl_state_t              state_reg, state_next;
    logic                     wake_mode_reg, wake_mode_next;
    phase_t                   phase_reg, phase_next;
    logic [1:0]               byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]        addr_high_reg, addr_high_next;
    logic [ADDR_W-1:0]        cur_addr_reg, cur_addr_next;
    logic [MEM_AW-1:0]        clr_cnt_reg, clr_cnt_next;

    logic                     pend_send_reg, pend_send_next;
    logic                     pend_stored_reg, pend_stored_next;
    logic                     pend_woke_reg, pend_woke_next;
    logic                     pend_byaddr_reg, pend_byaddr_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [15:0]              m_tdata_reg, m_tdata_next;

    logic                     mem_we, mem_re;
    logic [MEM_AW-1:0]        mem_waddr, mem_raddr;
    logic [BYTE_W-1:0]        mem_wdata, mem_rdata;

    logic                     accept;
    logic                     out_free;
    logic                     slave_read;
    logic [BYTE_W-1:0]        rx_byte;
    logic [MEM_AW-1:0]        cur_index;
    logic [BYTE_W-1:0]        send_byte;

    assign slave_read = s_tdata[0];
    assign rx_byte    = s_tdata[8:1];
    assign cur_index  = cur_addr_reg[MEM_AW-1:0];
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign send_byte  = pend_send_reg ? mem_rdata : '0;

    i2csm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            wake_mode_reg  <= 1'b0;
            phase_reg      <= PH_ADDR;
            byte_count_reg <= '0;
            addr_high_reg  <= '0;
            cur_addr_reg   <= '0;
            clr_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wake_mode_reg  <= wake_mode_next;
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            addr_high_reg  <= addr_high_next;
            cur_addr_reg   <= cur_addr_next;
            clr_cnt_reg    <= clr_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        pend_send_reg   <= pend_send_next;
        pend_stored_reg <= pend_stored_next;
        pend_woke_reg   <= pend_woke_next;
        pend_byaddr_reg <= pend_byaddr_next;
        m_tdata_reg     <= m_tdata_next;
    end

    always_comb begin
        state_next       = state_reg;
        wake_mode_next   = wake_mode_reg;
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        addr_high_next   = addr_high_reg;
        cur_addr_next    = cur_addr_reg;
        clr_cnt_next     = clr_cnt_reg;
        pend_send_next   = pend_send_reg;
        pend_stored_next = pend_stored_reg;
        pend_woke_next   = pend_woke_reg;
        pend_byaddr_next = pend_byaddr_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        mem_we           = 1'b0;
        mem_waddr        = cur_index;
        mem_wdata        = rx_byte;
        mem_re           = 1'b0;
        mem_raddr        = cur_index;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next       = ST_DONE;
                    pend_send_next   = 1'b0;
                    pend_stored_next = 1'b0;
                    pend_woke_next   = 1'b0;
                    pend_byaddr_next = 1'b0;
                    priority case (s_tuser)
                        ACT_START, ACT_NACK, ACT_STOP: begin
                            byte_count_next = '0;
                            phase_next      = PH_ADDR;
                        end
                        ACT_ACK: begin
                            if (phase_reg == PH_ADDR) begin
                                byte_count_next = '0;
                                if (slave_read) begin
                                    phase_next     = PH_SEND;
                                    pend_send_next = 1'b1;
                                    mem_re         = 1'b1;
                                    cur_addr_next  = cur_addr_reg + 1'b1;
                                end else begin
                                    phase_next = PH_RECV;
                                end
                            end else if (phase_reg == PH_RECV) begin
                                priority case (byte_count_reg)
                                    2'd1: begin
                                        cur_addr_next   = {addr_high_reg, rx_byte};
                                        byte_count_next = 2'd2;
                                    end
                                    2'd2: begin
                                        mem_we           = 1'b1;
                                        pend_stored_next = 1'b1;
                                        byte_count_next  = '0;
                                    end
                                    default: begin
                                        addr_high_next  = rx_byte;
                                        byte_count_next = 2'd1;
                                    end
                                endcase
                            end
                        end
                        ACT_WAKE: begin
                            pend_woke_next   = 1'b1;
                            pend_byaddr_next = wake_mode_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DONE: begin
                // Wait here while the previous result is still held downstream.
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, pend_byaddr_reg, pend_woke_reg, pend_stored_reg,
                                     send_byte, pend_send_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // The user must apply configuration writes only while no event is in flight; the block does not enforce this.
        if (cfg_wr_en) begin
            wake_mode_next = cfg_wr_data;
            phase_next     = start_phase(cfg_wr_data);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An event is followed by the lookup state: s_tready is low in the cycle after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("event taken while the previous one was still in progress");

    // A new result only appears from the lookup state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result registered outside the lookup state");

    // The byte counter never reaches three.
    a_byte_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg != 2'd3)
        else $error("byte counter out of range");

    // A result without a send carries a zero byte.
    a_send_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tdata_reg[0] |-> m_tdata_reg[8:1] == '0)
        else $error("send byte not zero without a send");

    // Memory reads are only issued for an accepted event.
    a_read_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |-> accept && state_reg == ST_IDLE)
        else $error("memory read outside an accepted event");

endmodule

>>> tb/sv/i2csm_result_board_pkg.sv
`timescale 1ns / 100ps
// Result board for the I2C slave memory event handler testbench: a cycle-free model of the
// event handler's memory and phase logic, plus the queue of result words it predicts.
// Depends on i2csm_pkg for the event codes, the phase type and the memory depth.
package i2csm_result_board_pkg;
    import i2csm_pkg::*;

    class i2csm_result_board;
        logic         wake_mode;
        phase_t       phase;
        logic [1:0]   byte_count;
        logic [7:0]   addr_high;
        logic [15:0]  cur_addr;
        logic [7:0]   mem [MEM_DEPTH];
        logic [15:0]  expected_words [$];
        int unsigned  mismatches;
        int unsigned  results_seen;
        int unsigned  sends;
        int unsigned  stores;
        int unsigned  wakes;

        function new();
            clear_state();
            mismatches   = 0;
            results_seen = 0;
            sends        = 0;
            stores       = 0;
            wakes        = 0;
        endfunction

        function void clear_state();
            wake_mode  = 1'b0;
            phase      = PH_ADDR;
            byte_count = 2'd0;
            addr_high  = 8'h00;
            cur_addr   = 16'h0000;
            for (int i = 0; i < MEM_DEPTH; i++) begin
                mem[i] = 8'h00;
            end
        endfunction

        // A mode write also moves the phase to that mode's starting point.
        function void set_mode(input logic m);
            wake_mode = m;
            phase     = m ? PH_RECV : PH_ADDR;
        endfunction

        function void note_event(input logic [2:0] act, input logic rd, input logic [7:0] rx);
            logic       snd_v;
            logic [7:0] snd_b;
            logic       st;
            logic       wk;
            logic       by_addr;
            snd_v   = 1'b0;
            snd_b   = 8'h00;
            st      = 1'b0;
            wk      = 1'b0;
            by_addr = 1'b0;
            case (act)
                ACT_START, ACT_NACK, ACT_STOP: begin
                    byte_count = 2'd0;
                    phase      = PH_ADDR;
                end
                ACT_ACK: begin
                    if (phase == PH_ADDR) begin
                        byte_count = 2'd0;
                        if (rd) begin
                            phase    = PH_SEND;
                            snd_v    = 1'b1;
                            snd_b    = mem[cur_addr % MEM_DEPTH];
                            cur_addr = cur_addr + 16'd1;
                        end else begin
                            phase = PH_RECV;
                        end
                    end else if (phase == PH_RECV) begin
                        if (byte_count == 2'd1) begin
                            cur_addr   = {addr_high, rx};
                            byte_count = 2'd2;
                        end else if (byte_count == 2'd2) begin
                            mem[cur_addr % MEM_DEPTH] = rx;
                            st         = 1'b1;
                            byte_count = 2'd0;
                        end else begin
                            addr_high  = rx;
                            byte_count = 2'd1;
                        end
                    end
                end
                ACT_WAKE: begin
                    wk      = 1'b1;
                    by_addr = wake_mode;
                end
                default: begin
                end
            endcase
            sends  += snd_v;
            stores += st;
            wakes  += wk;
            expected_words.push_back({4'b0000, by_addr, wk, st, snd_b, snd_v});
        endfunction

        function void check_word(input logic [15:0] got);
            logic [15:0] want;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result transaction %04h with nothing pending", got);
                end
                return;
            end
            want = expected_words.pop_front();
            results_seen++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected send_valid=%0b send_byte=%02h stored=%0b woke=%0b by_addr=%0b (%04h)",
                             results_seen, want[0], want[8:1], want[9], want[10], want[11],
                             want);
                    $display("result %0d:      got send_valid=%0b send_byte=%02h stored=%0b woke=%0b by_addr=%0b (%04h)",
                             results_seen, got[0], got[8:1], got[9], got[10], got[11], got);
                end
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb_i2c_slave_memory_event_handler.sv
`timescale 1ns / 100ps
// Testbench top for i2c_slave_memory_event_handler: drives bus event transactions with random
// gaps and output stalls, and checks every result against i2csm_result_board_pkg.
// Depends on i2csm_pkg, i2csm_result_board_pkg and the RTL of the event handler.
module tb_i2c_slave_memory_event_handler;
    import i2csm_pkg::*;
    import i2csm_result_board_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned ITEM_TARGET   = 1600;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam logic [2:0]  ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  ACT_SPARE_LAST  = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;   // [0] slave_read, [8:1] rx_byte, [15:9] zero
    logic [2:0]  s_tuser = ACT_START;  // [2:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;              // [0] send_valid, [8:1] send_byte, [9] stored,
                                       // [10] woke, [11] woke_by_address, [15:12] zero

    i2csm_result_board board = new();
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned modes_written = 0;
    bit          full_rate = 1'b0;

    i2c_slave_memory_event_handler DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            board.check_word(m_tdata);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     board.expected_words.size());
            $display("tb_i2c_slave_memory_event_handler failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_addr_high();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'h00;
        if (r < 55) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Low bytes cluster on a few cells so that reads often find written data.
    function automatic logic [7:0] pick_addr_low();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 8'($urandom_range(0, 15));
        if (r < 60) return 8'hFF;
        if (r < 70) return 8'($urandom_range(8'hF0, 8'hFF));
        return 8'($urandom_range(0, 255));
    endfunction

    // Result ready: random stalls, released entirely while the run is at full rate.
    initial begin
        int unsigned hold;
        hold = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (full_rate) begin
                hold = 0;
            end
            if (hold != 0) begin
                m_tready = 1'b0;
                hold--;
            end else begin
                m_tready = 1'b1;
                if (!full_rate && $urandom_range(0, 99) < 25) begin
                    hold = pick_gap();
                end
            end
        end
    end

    // The caller must not consume time between calls, or the held transaction would repeat.
    // Fields arrive as plain numbers and are cut to their widths here.
    task automatic send_event(input int unsigned act, input int unsigned rd,
                              input int unsigned rx);
        int unsigned gap;
        logic [2:0]  act_f;
        logic        rd_f;
        logic [7:0]  rx_f;
        act_f = 3'(act);
        rd_f  = 1'(rd);
        rx_f  = 8'(rx);
        gap = full_rate ? 0 : pick_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = act_f;
        s_tdata  = {7'b0000000, rx_f, rd_f};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_event(act_f, rd_f, rx_f);
        if (act_f <= ACT_WAKE) begin
            items_sent++;
        end
    endtask

    task automatic go_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (board.expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        board.set_mode(m);
        modes_written++;
    endtask

    task automatic maybe_wake();
        if ($urandom_range(0, 19) == 0) begin
            send_event(ACT_WAKE, $urandom_range(0, 1), $urandom_range(0, 255));
        end
    endtask

    task automatic write_transfer();
        int unsigned n;
        send_event(ACT_START, $urandom_range(0, 1), $urandom_range(0, 255));
        send_event(ACT_ACK, 1'b0, $urandom_range(0, 255));
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            send_event(ACT_ACK, $urandom_range(0, 1), pick_addr_high());
            maybe_wake();
            if ($urandom_range(0, 99) < 8) break;
            send_event(ACT_ACK, $urandom_range(0, 1), pick_addr_low());
            if ($urandom_range(0, 99) < 8) break;
            send_event(ACT_ACK, $urandom_range(0, 1), $urandom_range(0, 255));
            maybe_wake();
        end
        send_event($urandom_range(0, 1) ? ACT_STOP : ACT_NACK, $urandom_range(0, 1),
                   $urandom_range(0, 255));
    endtask

    // Sets the pointer with a write, then reads from it after a repeated start.
    task automatic pointer_read();
        int unsigned k;
        send_event(ACT_START, $urandom_range(0, 1), $urandom_range(0, 255));
        send_event(ACT_ACK, 1'b0, $urandom_range(0, 255));
        send_event(ACT_ACK, $urandom_range(0, 1), pick_addr_high());
        send_event(ACT_ACK, $urandom_range(0, 1), pick_addr_low());
        send_event(ACT_START, $urandom_range(0, 1), $urandom_range(0, 255));
        send_event(ACT_ACK, 1'b1, $urandom_range(0, 255));
        k = $urandom_range(0, 4);
        for (int i = 0; i < k; i++) begin
            send_event(ACT_ACK, $urandom_range(0, 1), $urandom_range(0, 255));
        end
        send_event(ACT_NACK, $urandom_range(0, 1), $urandom_range(0, 255));
        send_event(ACT_STOP, $urandom_range(0, 1), $urandom_range(0, 255));
    endtask

    task automatic plain_read();
        int unsigned k;
        send_event(ACT_START, $urandom_range(0, 1), $urandom_range(0, 255));
        send_event(ACT_ACK, 1'b1, $urandom_range(0, 255));
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) begin
            send_event(ACT_ACK, $urandom_range(0, 1), $urandom_range(0, 255));
            maybe_wake();
        end
        send_event(ACT_NACK, $urandom_range(0, 1), $urandom_range(0, 255));
        send_event(ACT_STOP, $urandom_range(0, 1), $urandom_range(0, 255));
    endtask

    task automatic noise();
        int unsigned n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            send_event($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 255));
        end
    endtask

    task automatic directed_events();
        // Toggle mode: wake-up, then writes at the top of the address range and at an address that maps to cell zero.
        send_event(ACT_WAKE, 1'b1, 8'hFF);
        send_event(ACT_START, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b0, 8'hFF);
        send_event(ACT_ACK, 1'b0, 8'hFF);
        send_event(ACT_ACK, 1'b1, 8'hFF);
        send_event(ACT_ACK, 1'b0, 8'hA5);
        send_event(ACT_ACK, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b0, 8'h5A);
        // Read after a repeated start; the further ack while sending changes nothing.
        send_event(ACT_START, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b1, 8'h00);
        send_event(ACT_ACK, 1'b1, 8'hFF);
        send_event(ACT_NACK, 1'b0, 8'h00);
        // Pointer at the last address: the read there wraps the address to zero.
        send_event(ACT_START, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b0, 8'hFF);
        send_event(ACT_ACK, 1'b0, 8'hFF);
        send_event(ACT_START, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b1, 8'h00);
        send_event(ACT_STOP, 1'b0, 8'h00);
        send_event(ACT_START, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b1, 8'h00);
        send_event(ACT_STOP, 1'b1, 8'hFF);
        for (logic [3:0] a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) begin
            send_event(a[2:0], 1'b1, 8'hFF);
        end
        go_idle();
        drain();
        // Address-match mode starts in the receiving phase, so no start is needed.
        write_mode(1'b1);
        send_event(ACT_WAKE, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b0, 8'h12);
        send_event(ACT_ACK, 1'b0, 8'h80);
        send_event(ACT_ACK, 1'b0, 8'hC3);
        send_event(ACT_START, 1'b0, 8'h00);
        send_event(ACT_ACK, 1'b1, 8'h00);
        send_event(ACT_STOP, 1'b0, 8'h00);
        go_idle();
    endtask

    initial begin
        int unsigned r;
        int unsigned phase_target;
        logic        m;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // The memory clearing pass holds off input transactions.
        do @(posedge aclk); while (!s_tready);
        write_mode(1'b0);
        directed_events();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            m = (p % 2 == 0);
            write_mode(m);
            full_rate = (p == 2);
            phase_target = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - p);
            if (m) begin
                send_event(ACT_ACK, $urandom_range(0, 1), pick_addr_high());
                send_event(ACT_ACK, $urandom_range(0, 1), pick_addr_low());
                send_event(ACT_ACK, $urandom_range(0, 1), $urandom_range(0, 255));
            end
            while (items_sent < phase_target) begin
                r = $urandom_range(0, 99);
                if (r < 40) write_transfer();
                else if (r < 65) pointer_read();
                else if (r < 80) plain_read();
                else noise();
            end
            go_idle();
            full_rate = 1'b0;
        end

        drain();
        repeat (8) @(posedge aclk);
        r = board.expected_words.size();
        $display("checked %0d results from %0d events over %0d mode writes", board.results_seen,
                 items_sent, modes_written);
        $display("the run stored %0d bytes, loaded %0d bytes for sending and saw %0d wake-ups",
                 board.stores, board.sends, board.wakes);
        if (board.mismatches == 0 && r == 0) begin
            $display("tb_i2c_slave_memory_event_handler passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived", board.mismatches, r);
            $display("tb_i2c_slave_memory_event_handler failed");
        end
        $finish;
    end

endmodule
